// ===== rtl/salcc_pkg.sv =====
// Shared constants and types of the set associative LRU cache classifier.
`default_nettype none

package salcc_pkg;

    localparam int WL_W = 2;
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic hit;
        logic fill;
    } salcc_status_t;

endpackage

`default_nettype wire

// ===== rtl/salcc_ram.sv =====
// Synchronous row memory with one write port and one registered read port.
`default_nettype none

module salcc_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/salcc_lookup.sv =====
// Way compare, victim choice and age update for one cache row.
`default_nettype none

module salcc_lookup #(
    parameter int MAX_WAYS  = 4,
    parameter int ADDR_BITS = 16,
    parameter int BANK_W    = 2
) (
    input  wire logic [ADDR_BITS-1:0]                 addr,
    input  wire logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   row_tags,
    input  wire logic [MAX_WAYS-1:0][BANK_W-1:0]      row_ages,
    input  wire logic [MAX_WAYS-1:0]                  row_valid,
    input  wire logic [BANK_W-1:0]                    offset,
    input  wire logic [salcc_pkg::WL_W-1:0]           eff_log,
    output salcc_pkg::salcc_status_t                  status,
    output logic      [MAX_WAYS-1:0]                  sel,
    output logic      [MAX_WAYS-1:0][ADDR_BITS-1:0]   new_tags,
    output logic      [MAX_WAYS-1:0][BANK_W-1:0]      new_ages
);

    import salcc_pkg::*;

    logic [MAX_WAYS-1:0] in_set;
    logic [MAX_WAYS-1:0] hit_oh;
    logic [MAX_WAYS-1:0] free_oh;
    logic [MAX_WAYS-1:0] old_oh;
    logic                found;
    logic                have_free;
    logic                have_any;
    logic [BANK_W-1:0]   best_age;
    logic [BANK_W-1:0]   hit_age;
    logic [BANK_W-1:0]   lim;
    logic                bump;

    always_comb
    begin
        found     = 1'b0;
        have_free = 1'b0;
        have_any  = 1'b0;
        hit_oh    = '0;
        free_oh   = '0;
        old_oh    = '0;
        best_age  = '0;
        hit_age   = '0;
        lim       = BANK_W'((32'd1 << eff_log) - 32'd1);
        for (int b = 0; b < MAX_WAYS; b++)
        begin
            in_set[b] = ((BANK_W'(b) ^ offset) >> eff_log) == '0;
            if (in_set[b] && row_valid[b] && row_tags[b] == addr && !found)
            begin
                found     = 1'b1;
                hit_oh[b] = 1'b1;
                hit_age   = row_ages[b];
            end
            if (in_set[b] && !row_valid[b] && !have_free)
            begin
                have_free  = 1'b1;
                free_oh[b] = 1'b1;
            end
            if (in_set[b] && (!have_any || row_ages[b] > best_age))
            begin
                have_any  = 1'b1;
                best_age  = row_ages[b];
                old_oh    = '0;
                old_oh[b] = 1'b1;
            end
        end

        if (found)
        begin
            sel = hit_oh;
        end
        else if (have_free)
        begin
            sel = free_oh;
        end
        else
        begin
            sel = old_oh;
        end

        for (int b = 0; b < MAX_WAYS; b++)
        begin
            bump = found ? (row_ages[b] < hit_age) : (row_ages[b] < lim);
            new_tags[b] = sel[b] ? addr : row_tags[b];
            if (sel[b])
            begin
                new_ages[b] = '0;
            end
            else if (in_set[b] && row_valid[b] && bump)
            begin
                new_ages[b] = row_ages[b] + 1'b1;
            end
            else
            begin
                new_ages[b] = row_ages[b];
            end
        end

        status.hit  = found;
        status.fill = !found;
    end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_classifier_top.sv =====
// Top level of the set associative LRU cache classifier.
`default_nettype none

// Classifies one block address per word as a hit or a miss in a cache of
// CACHE_BLOCKS blocks with 1, 2 or 4 ways (ways_log2), and returns the hit
// flag with saturating hit and access totals. It takes one word per cycle
// unless out_ready stalls the output; a word is registered in a stage
// and its result in the output register. MAX_WAYS consecutive entries
// share a row of tags and ages in a synchronous RAM, read as the address
// is taken and written back as the word leaves the stage, with the last
// written row forwarded to the lookup. Reset clears the valid flip-flops,
// so the block needs no clearing pass. Write ways_log2 only while idle.
module set_assoc_lru_cache_classifier_top #(
    parameter int CACHE_BLOCKS = 256,
    parameter int MAX_WAYS     = 4,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [salcc_pkg::WL_W-1:0]    ways_log2,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ADDR_BITS-1:0]          block_address,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic      [salcc_pkg::CNT_W-1:0]   hit_total,
    output logic      [salcc_pkg::CNT_W-1:0]   access_total
);

    import salcc_pkg::*;

    localparam int LOG_MW   = $clog2(MAX_WAYS);
    localparam int BANK_W   = (LOG_MW > 0) ? LOG_MW : 1;
    localparam int EIDX_W   = $clog2(CACHE_BLOCKS);
    localparam int ROWS     = CACHE_BLOCKS / MAX_WAYS;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int AX_W     = (ADDR_BITS > EIDX_W) ? ADDR_BITS : EIDX_W;
    localparam int TAG_BITS = MAX_WAYS * ADDR_BITS;
    localparam int ROW_BITS = MAX_WAYS * (ADDR_BITS + BANK_W);

    logic [WL_W-1:0]      ways_log2_reg;
    logic [WL_W-1:0]      eff_log;

    logic                 in_fire;
    logic                 s1_go;
    logic [EIDX_W-1:0]    addr_low;
    logic [EIDX_W-1:0]    set_mask;
    logic [EIDX_W-1:0]    base;
    logic [ROW_W-1:0]     s0_row;
    logic [BANK_W-1:0]    s0_offset;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [BANK_W-1:0]    s1_offset_reg;

    logic [ROW_BITS-1:0]  rd_data;
    logic [ROW_BITS-1:0]  row_data;
    logic [ROW_BITS-1:0]  wr_data;
    logic                 fwd_valid_reg;
    logic [ROW_W-1:0]     fwd_row_reg;
    logic [ROW_BITS-1:0]  fwd_data_reg;

    logic [MAX_WAYS-1:0]  valid_reg [ROWS];

    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] row_tags;
    logic [MAX_WAYS-1:0][BANK_W-1:0]    row_ages;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tags;
    logic [MAX_WAYS-1:0][BANK_W-1:0]    new_ages;
    logic [MAX_WAYS-1:0]                sel;
    salcc_status_t                      status;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [CNT_W-1:0]     hit_count_reg;
    logic [CNT_W-1:0]     access_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_log2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            ways_log2_reg <= ways_log2;
        end
    end

    assign eff_log = (32'(ways_log2_reg) > LOG_MW) ? WL_W'(LOG_MW) : ways_log2_reg;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    // Locate the row and first bank of the set.
    assign addr_low  = EIDX_W'(AX_W'(block_address));
    assign set_mask  = {EIDX_W{1'b1}} >> eff_log;
    assign base      = (addr_low & set_mask) << eff_log;
    assign s0_row    = ROW_W'(base >> LOG_MW);
    assign s0_offset = BANK_W'(base & EIDX_W'(MAX_WAYS - 1));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg   <= block_address;
            s1_row_reg    <= s0_row;
            s1_offset_reg <= s0_offset;
        end
    end

    salcc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_row_reg),
        .wdata (wr_data),
        .re    (in_fire),
        .raddr (s0_row),
        .rdata (rd_data)
    );

    // Forward the last written row over stale read data.
    assign row_data = (fwd_valid_reg && fwd_row_reg == s1_row_reg) ? fwd_data_reg : rd_data;
    assign row_tags = row_data[TAG_BITS-1:0];
    assign row_ages = row_data[ROW_BITS-1:TAG_BITS];
    assign wr_data  = {new_ages, new_tags};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            fwd_row_reg  <= s1_row_reg;
            fwd_data_reg <= wr_data;
        end
    end

    salcc_lookup #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .BANK_W    (BANK_W)
    ) u_lookup (
        .addr      (s1_addr_reg),
        .row_tags  (row_tags),
        .row_ages  (row_ages),
        .row_valid (valid_reg[s1_row_reg]),
        .offset    (s1_offset_reg),
        .eff_log   (eff_log),
        .status    (status),
        .sel       (sel),
        .new_tags  (new_tags),
        .new_ages  (new_ages)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                valid_reg[r] <= '0;
            end
        end
        else if (s1_go && status.fill)
        begin
            valid_reg[s1_row_reg] <= valid_reg[s1_row_reg] | sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            hit_count_reg    <= '0;
            access_count_reg <= '0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
            hit_reg       <= status.hit;
            if (access_count_reg != CNT_MAX)
            begin
                access_count_reg <= access_count_reg + 1'b1;
            end
            if (status.hit && hit_count_reg != CNT_MAX)
            begin
                hit_count_reg <= hit_count_reg + 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_total    = hit_count_reg;
    assign access_total = access_count_reg;

endmodule

`default_nettype wire

// ===== rtl/salcc_checker.sv =====
// Port level checks of the cache classifier and their binding to the top level.
`default_nettype none

module salcc_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic                        hit,
    input  wire logic [salcc_pkg::CNT_W-1:0] hit_total,
    input  wire logic [salcc_pkg::CNT_W-1:0] access_total
);

    import salcc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_total)
            && $stable(access_total))
        else $error("result word changed while stalled");

    a_access_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid |->
            access_total == (($past(access_total) == CNT_MAX) ? CNT_MAX
                                                               : $past(access_total) + 1'b1))
        else $error("access total did not advance by one");

    a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid |->
            hit_total == ((!hit || $past(hit_total) == CNT_MAX) ? $past(hit_total)
                                                                : $past(hit_total) + 1'b1))
        else $error("hit total does not follow the hit flag");

    a_hit_le_access: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit_total <= access_total)
        else $error("hit total exceeds access total");

endmodule

bind set_assoc_lru_cache_classifier_top salcc_checker u_salcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_total    (hit_total),
    .access_total (access_total)
);

`default_nettype wire

// ===== verif/set_assoc_lru_cache_classifier_top_test.sv =====
// Self-checking testbench for the set associative LRU cache classifier top level.
`default_nettype none

localparam int TRACK_BLOCKS   = 256;
localparam int TRACK_MAX_WAYS = 4;
localparam int TRACK_ADDR_W   = 16;

localparam logic [salcc_pkg::WL_W-1:0] WAYS_DIRECT = 2'd0;
localparam logic [salcc_pkg::WL_W-1:0] WAYS_TWO    = 2'd1;
localparam logic [salcc_pkg::WL_W-1:0] WAYS_FOUR   = 2'd2;
localparam logic [salcc_pkg::WL_W-1:0] WAYS_EIGHT  = 2'd3;

typedef struct packed {
    logic                         hit;
    logic [salcc_pkg::CNT_W-1:0]  hit_total;
    logic [salcc_pkg::CNT_W-1:0]  access_total;
} lookup_verdict_t;

class cache_tracker;
    logic [TRACK_ADDR_W-1:0]      tags [TRACK_BLOCKS];
    bit                           valid [TRACK_BLOCKS];
    bit [1:0]                     age [TRACK_BLOCKS];
    logic [salcc_pkg::WL_W-1:0]   ways_code;
    bit [salcc_pkg::CNT_W-1:0]    hits;
    bit [salcc_pkg::CNT_W-1:0]    accesses;
    lookup_verdict_t              pending_verdicts [$];
    int                           faults;

    function new();
        for (int e = 0; e < TRACK_BLOCKS; e++)
        begin
            tags[e]  = '0;
            valid[e] = 1'b0;
            age[e]   = 2'd0;
        end
        ways_code = WAYS_DIRECT;
        hits      = '0;
        accesses  = '0;
        faults    = 0;
    endfunction

    function void note_lookup(logic [TRACK_ADDR_W-1:0] addr);
        int nways;
        int sets;
        int base;
        int sel;
        int e;
        bit found;
        bit vacant;
        bit [1:0] hit_age;
        bit [1:0] oldest;
        lookup_verdict_t v;
        nways = 1 << ways_code;
        if (nways > TRACK_MAX_WAYS)
            nways = TRACK_MAX_WAYS;
        sets  = TRACK_BLOCKS / nways;
        base  = (int'(addr) % sets) * nways;
        found = 1'b0;
        sel   = 0;
        for (int w = 0; w < nways; w++)
        begin
            e = base + w;
            if (!found && valid[e] && tags[e] == addr)
            begin
                found = 1'b1;
                sel   = w;
            end
        end
        if (found)
        begin
            hit_age = age[base + sel];
            for (int w = 0; w < nways; w++)
            begin
                e = base + w;
                if (w != sel && valid[e] && age[e] < hit_age)
                    age[e] = age[e] + 2'd1;
            end
            age[base + sel] = 2'd0;
            if (hits != '1)
                hits = hits + 1;
        end
        else
        begin
            vacant = 1'b0;
            for (int w = 0; w < nways; w++)
            begin
                if (!vacant && !valid[base + w])
                begin
                    vacant = 1'b1;
                    sel    = w;
                end
            end
            if (!vacant)
            begin
                sel    = 0;
                oldest = age[base];
                for (int w = 1; w < nways; w++)
                begin
                    if (age[base + w] > oldest)
                    begin
                        oldest = age[base + w];
                        sel    = w;
                    end
                end
            end
            for (int w = 0; w < nways; w++)
            begin
                e = base + w;
                if (w != sel && valid[e] && int'(age[e]) + 1 < nways)
                    age[e] = age[e] + 2'd1;
            end
            tags[base + sel]  = addr;
            valid[base + sel] = 1'b1;
            age[base + sel]   = 2'd0;
        end
        if (accesses != '1)
            accesses = accesses + 1;
        v.hit          = found;
        v.hit_total    = hits;
        v.access_total = accesses;
        pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic got_hit, logic [salcc_pkg::CNT_W-1:0] got_hits,
                                logic [salcc_pkg::CNT_W-1:0] got_accesses);
        lookup_verdict_t want;
        if (pending_verdicts.size() == 0)
        begin
            $error("result word with no lookup pending");
            faults++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (got_hit !== want.hit)
        begin
            $error("hit: expected %0d, got %0d", want.hit, got_hit);
            faults++;
        end
        if (got_hits !== want.hit_total)
        begin
            $error("hit_total: expected %0d, got %0d", want.hit_total, got_hits);
            faults++;
        end
        if (got_accesses !== want.access_total)
        begin
            $error("access_total: expected %0d, got %0d", want.access_total, got_accesses);
            faults++;
        end
    endfunction
endclass

module set_assoc_lru_cache_classifier_top_test;
    import salcc_pkg::*;

    localparam logic [TRACK_ADDR_W-1:0] DIRECT_SEQ [8] = '{
        16'd0, 16'd0, 16'd256, 16'd0, 16'd65535, 16'd65535, 16'd65279, 16'd65535
    };
    localparam logic [TRACK_ADDR_W-1:0] FOUR_WAY_SEQ [11] = '{
        16'd5, 16'd69, 16'd133, 16'd197, 16'd69, 16'd5,
        16'd261, 16'd133, 16'd197, 16'd69, 16'd65535
    };
    localparam logic [WL_W-1:0] PHASE_WAYS [6] = '{
        WAYS_FOUR, WAYS_TWO, WAYS_DIRECT, WAYS_EIGHT, WAYS_TWO, WAYS_FOUR
    };
    localparam int PHASE_LOOKUPS = 117;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [WL_W-1:0]          ways_log2 = WAYS_DIRECT;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [TRACK_ADDR_W-1:0]  block_address = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     hit;
    logic [CNT_W-1:0]         hit_total;
    logic [CNT_W-1:0]         access_total;

    cache_tracker tracker;
    bit           steady = 1'b0;
    int           hold_left = 0;

    set_assoc_lru_cache_classifier_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .ways_log2     (ways_log2),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_address (block_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .hit_total     (hit_total),
        .access_total  (access_total)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int idle_span();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_verdict(hit, hit_total, access_total);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            hold_left <= idle_span() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic offer_address(input logic [TRACK_ADDR_W-1:0] addr, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        block_address <= addr;
        do @(posedge clk); while (!in_ready);
        tracker.note_lookup(addr);
    endtask

    task automatic drain_lookups();
        in_valid <= 1'b0;
        while (tracker.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ways(input logic [WL_W-1:0] code);
        drain_lookups();
        cfg_valid <= 1'b1;
        ways_log2 <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.ways_code = code;
    endtask

    initial
    begin
        int                       hot_set [4];
        logic [TRACK_ADDR_W-1:0]  hot_pool [16];
        logic [TRACK_ADDR_W-1:0]  addr;
        int                       gap;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECT_SEQ[i])
            offer_address(DIRECT_SEQ[i], 0);
        write_ways(WAYS_FOUR);
        foreach (FOUR_WAY_SEQ[i])
            offer_address(FOUR_WAY_SEQ[i], (i % 3 == 2) ? 1 : 0);

        foreach (PHASE_WAYS[p])
        begin
            write_ways(PHASE_WAYS[p]);
            steady = (p == 3);
            for (int i = 0; i < 4; i++)
                hot_set[i] = $urandom_range(0, 63);
            for (int i = 0; i < 16; i++)
                hot_pool[i] = TRACK_ADDR_W'(hot_set[i % 4] + 64 * ((i < 13)
                              ? $urandom_range(0, 7) : $urandom_range(0, 1023)));
            for (int n = 0; n < PHASE_LOOKUPS; n++)
            begin
                if (n == 60)
                    drain_lookups();
                if ($urandom_range(0, 99) < 75)
                    addr = hot_pool[$urandom_range(0, 15)];
                else
                    addr = TRACK_ADDR_W'($urandom_range(0, 65535));
                gap = (!steady && $urandom_range(0, 99) < 30) ? idle_span() : 0;
                offer_address(addr, gap);
            end
        end

        drain_lookups();
        repeat (8) @(posedge clk);
        if (tracker.faults == 0 && tracker.pending_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== set_assoc_lru_cache_classifier_top.f =====
rtl/salcc_pkg.sv
rtl/salcc_ram.sv
rtl/salcc_lookup.sv
rtl/set_assoc_lru_cache_classifier_top.sv
rtl/salcc_checker.sv
verif/set_assoc_lru_cache_classifier_top_test.sv
